[hdl/lts_pkg.sv]
// Shared types and constants for the lottery ticket scheduler.
`default_nettype none

package lts_pkg;

    localparam int ID_W     = 16;
    localparam int TICKET_W = 16;
    localparam int DRAW_W   = 20;
    localparam int TOTAL_W  = 20;

    localparam logic [TICKET_W-1:0] TICKET_MAX = 16'hFFFF;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 20'hFFFFF;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_ALLOC  = 2'd1,
        KIND_SELECT = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TICKET_W-1:0] tickets;
    } entry_t;

    typedef struct packed {
        logic reach;
        logic match;
    } step_flags_t;

endpackage

`default_nettype wire

[hdl/lts_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [AW-1:0]         raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/lts_step_unit.sv]
// Shared step unit: running-sum add, draw compare, id match, saturating credit.
`default_nettype none

module lts_step_unit #(
    parameter int SUM_W = 21
) (
    input  wire logic [SUM_W-1:0]             acc,
    input  wire logic [lts_pkg::TICKET_W-1:0] ticket,
    input  wire logic [lts_pkg::TICKET_W-1:0] amount,
    input  wire logic [lts_pkg::DRAW_W-1:0]   draw,
    input  wire logic [lts_pkg::ID_W-1:0]     entry_id,
    input  wire logic [lts_pkg::ID_W-1:0]     client_id,
    output logic      [SUM_W-1:0]             sum,
    output logic      [lts_pkg::TICKET_W-1:0] sat_ticket,
    output lts_pkg::step_flags_t              flags
);

    logic [lts_pkg::TICKET_W:0] credit;

    always_comb
    begin
        sum         = acc + SUM_W'(ticket);
        flags.reach = (sum >= SUM_W'(draw));
        flags.match = (entry_id == client_id);
        credit      = {1'b0, ticket} + {1'b0, amount};
        sat_ticket  = credit[lts_pkg::TICKET_W] ? lts_pkg::TICKET_MAX
                                                : credit[lts_pkg::TICKET_W-1:0];
    end

endmodule

`default_nettype wire

[hdl/lottery_ticket_scheduler.sv]
// Lottery ticket scheduler top level: sequencer, entry table and result register.
//
// Input channel (in_valid/in_ready): kind, client_id, ticket_amount, draw.
// Output channel (out_valid/out_ready): status, winner_id, total_tickets.
// Exactly one result per accepted item. One item is in work at a time;
// in_ready is high only while the sequencer is idle.
// Add, unused kind, allocate or select on an empty table and out-of-range
// draws finish without a walk, going straight from idle to the done state.
// Allocate and select walk the entry RAM one entry per cycle through the
// shared step unit until a match or reach or the last entry, then go to
// the done state, which loads the output register once it is free.
// The running ticket total is kept in a register, so no extra pass is needed.
// Reset clears the entry count, the total, the state and out_valid; the RAM is
// not cleared, only entries below the count are ever used.
// When the receiver stalls, a finished result waits in the output register;
// the block still takes one more item and holds its result until the output
// register frees up.
`default_nettype none

module lottery_ticket_scheduler #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     kind,
    input  wire logic [lts_pkg::ID_W-1:0]       client_id,
    input  wire logic [lts_pkg::TICKET_W-1:0]   ticket_amount,
    input  wire logic [lts_pkg::DRAW_W-1:0]     draw,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          status,
    output logic [lts_pkg::ID_W-1:0]            winner_id,
    output logic [lts_pkg::TOTAL_W-1:0]         total_tickets
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = (lts_pkg::TICKET_W + CW > lts_pkg::TOTAL_W)
                        ? lts_pkg::TICKET_W + CW : lts_pkg::TOTAL_W;
    localparam int EW = $bits(lts_pkg::entry_t);

    lts_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [TW-1:0]    run_reg, run_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [TW-1:0]    total_reg, total_next;
    logic             out_valid_reg, out_valid_next;

    lts_pkg::kind_t              kind_reg, kind_next;
    logic [lts_pkg::ID_W-1:0]     id_reg, id_next;
    logic [lts_pkg::TICKET_W-1:0] amount_reg, amount_next;
    logic [lts_pkg::DRAW_W-1:0]   draw_reg, draw_next;
    lts_pkg::status_t            res_status_reg, res_status_next;
    logic [lts_pkg::ID_W-1:0]     res_winner_reg, res_winner_next;
    lts_pkg::status_t            out_status_reg, out_status_next;
    logic [lts_pkg::ID_W-1:0]     out_winner_reg, out_winner_next;
    logic [lts_pkg::TOTAL_W-1:0]  out_total_reg, out_total_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    lts_pkg::entry_t              ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [EW-1:0]                ram_rdata;
    lts_pkg::entry_t              rd_entry;

    logic [TW-1:0]                step_sum;
    logic [lts_pkg::TICKET_W-1:0] step_sat;
    lts_pkg::step_flags_t         step_flags;

    logic                         accept;
    logic                         last_entry;
    logic [lts_pkg::TOTAL_W-1:0]  total_sat;

    assign rd_entry = lts_pkg::entry_t'(ram_rdata);

    lts_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lts_step_unit #(
        .SUM_W (TW)
    ) u_step (
        .acc        (run_reg),
        .ticket     (rd_entry.tickets),
        .amount     (amount_reg),
        .draw       (draw_reg),
        .entry_id   (rd_entry.id),
        .client_id  (id_reg),
        .sum        (step_sum),
        .sat_ticket (step_sat),
        .flags      (step_flags)
    );

    assign in_ready      = (state_reg == lts_pkg::S_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign winner_id     = out_winner_reg;
    assign total_tickets = out_total_reg;

    assign last_entry = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign total_sat  = (total_reg > TW'(lts_pkg::TOTAL_MAX))
                        ? lts_pkg::TOTAL_MAX : total_reg[lts_pkg::TOTAL_W-1:0];
    // Prefetch: entry 0 while idle, the next entry while walking.
    assign ram_raddr  = (state_reg == lts_pkg::S_IDLE) ? '0 : AW'(idx_reg + AW'(1));

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        out_valid_next  = out_valid_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        amount_next     = amount_reg;
        draw_next       = draw_reg;
        res_status_next = res_status_reg;
        res_winner_next = res_winner_reg;
        out_status_next = out_status_reg;
        out_winner_next = out_winner_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '{id: id_reg, tickets: step_sat};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    kind_next       = lts_pkg::kind_t'(kind);
                    id_next         = client_id;
                    amount_next     = ticket_amount;
                    draw_next       = draw;
                    idx_next        = '0;
                    run_next        = '0;
                    res_status_next = lts_pkg::ST_OK;
                    res_winner_next = '0;
                    state_next      = lts_pkg::S_DONE;
                    unique case (lts_pkg::kind_t'(kind))
                        lts_pkg::KIND_ADD:
                        begin
                            if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                res_status_next = lts_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = '{id: client_id, tickets: ticket_amount};
                                count_next = count_reg + CW'(1);
                                total_next = total_reg + TW'(ticket_amount);
                            end
                        end
                        lts_pkg::KIND_ALLOC:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = lts_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = lts_pkg::S_WALK;
                            end
                        end
                        lts_pkg::KIND_SELECT:
                        begin
                            priority if (count_reg == '0)
                            begin
                                res_status_next = lts_pkg::ST_EMPTY;
                            end
                            else if (draw == '0 || TW'(draw) > total_reg)
                            begin
                                res_status_next = lts_pkg::ST_RANGE;
                            end
                            else
                            begin
                                state_next = lts_pkg::S_WALK;
                            end
                        end
                        lts_pkg::KIND_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            lts_pkg::S_WALK:
            begin
                idx_next = AW'(idx_reg + AW'(1));
                run_next = step_sum;
                if (kind_reg == lts_pkg::KIND_SELECT)
                begin
                    if (step_flags.reach)
                    begin
                        res_winner_next = rd_entry.id;
                        state_next      = lts_pkg::S_DONE;
                    end
                    else if (last_entry)
                    begin
                        state_next = lts_pkg::S_DONE;
                    end
                end
                else
                begin
                    if (step_flags.match)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = idx_reg;
                        ram_wdata  = '{id: rd_entry.id, tickets: step_sat};
                        total_next = total_reg + TW'(step_sat - rd_entry.tickets);
                        state_next = lts_pkg::S_DONE;
                    end
                    else if (last_entry)
                    begin
                        res_status_next = lts_pkg::ST_NOT_FOUND;
                        state_next      = lts_pkg::S_DONE;
                    end
                end
            end

            lts_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_winner_next = res_winner_reg;
                    out_total_next  = total_sat;
                    state_next      = lts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lts_pkg::S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        amount_reg     <= amount_next;
        draw_reg       <= draw_next;
        res_status_reg <= res_status_next;
        res_winner_reg <= res_winner_next;
        out_status_reg <= out_status_next;
        out_winner_reg <= out_winner_next;
        out_total_reg  <= out_total_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lts_pkg::S_WALK) |-> (CW'(idx_reg) < count_reg))
        else $error("walk index beyond entry count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item taken while one is in work");

    a_winner_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status_reg != lts_pkg::ST_OK) |-> (winner_id == '0))
        else $error("winner id set on failed item");

endmodule

`default_nettype wire

[dv/lottery_ticket_scheduler_test.sv]
// Self-checking testbench for the lottery ticket scheduler: predicted results vs. DUT.
`timescale 1ns / 100ps

module lottery_ticket_scheduler_test;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 800;
    localparam int PHASE_ITEMS = 100;
    localparam int LIMIT       = 500000;

    localparam int ID_W     = lts_pkg::ID_W;
    localparam int TICKET_W = lts_pkg::TICKET_W;
    localparam int DRAW_W   = lts_pkg::DRAW_W;
    localparam int TOTAL_W  = lts_pkg::TOTAL_W;

    typedef struct {
        lts_pkg::status_t    status;
        logic [ID_W-1:0]     winner;
        logic [TOTAL_W-1:0]  total;
    } sched_result_t;

    class ticket_table_model;
        logic [ID_W-1:0]     ids [DEPTH];
        logic [TICKET_W-1:0] tix [DEPTH];
        int                  count;
        sched_result_t       owed [$];
        int                  errors;
        int                  seen;

        function new();
            count  = 0;
            errors = 0;
            seen   = 0;
        endfunction

        function int unsigned table_total();
            int unsigned sum;
            int          i;
            sum = 0;
            for (i = 0; i < count; i++)
                sum += tix[i];
            return sum;
        endfunction

        function logic [ID_W-1:0] pick_id();
            if (count == 0)
                return ID_W'($urandom_range(0, 65535));
            return ids[$urandom_range(0, count - 1)];
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void apply_item(logic [1:0] k, logic [ID_W-1:0] id,
                                 logic [TICKET_W-1:0] amt, logic [DRAW_W-1:0] d);
            sched_result_t r;
            int unsigned   sum;
            int unsigned   run;
            logic [16:0]   t;
            int            i;
            r.status = lts_pkg::ST_OK;
            r.winner = '0;
            case (lts_pkg::kind_t'(k))
                lts_pkg::KIND_ADD:
                begin
                    if (count >= DEPTH)
                        r.status = lts_pkg::ST_FULL;
                    else
                    begin
                        ids[count] = id;
                        tix[count] = amt;
                        count++;
                    end
                end
                lts_pkg::KIND_ALLOC:
                begin
                    r.status = lts_pkg::ST_NOT_FOUND;
                    for (i = 0; i < count; i++)
                    begin
                        if (ids[i] == id)
                        begin
                            t = {1'b0, tix[i]} + {1'b0, amt};
                            tix[i] = t[16] ? lts_pkg::TICKET_MAX : t[15:0];
                            r.status = lts_pkg::ST_OK;
                            break;
                        end
                    end
                end
                lts_pkg::KIND_SELECT:
                begin
                    if (count == 0)
                        r.status = lts_pkg::ST_EMPTY;
                    else if (d == 0 || d > table_total())
                        r.status = lts_pkg::ST_RANGE;
                    else
                    begin
                        run = 0;
                        for (i = 0; i < count; i++)
                        begin
                            run += tix[i];
                            if (run >= d)
                            begin
                                r.winner = ids[i];
                                break;
                            end
                        end
                    end
                end
                default: ;
            endcase
            sum = table_total();
            r.total = (sum > lts_pkg::TOTAL_MAX) ? lts_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
            owed.insert(owed.size(), r);
        endfunction

        task report(string what);
            errors++;
            $display("mismatch at result %0d: %s", seen, what);
        endtask

        task check_result(logic [2:0] st, logic [ID_W-1:0] win, logic [TOTAL_W-1:0] tot);
            sched_result_t e;
            if (owed.size() == 0)
            begin
                report($sformatf("unexpected result status %0d winner %h total %0d",
                                 st, win, tot));
                return;
            end
            e = owed.pop_front();
            seen++;
            if (st !== e.status)
                report($sformatf("status got %0d exp %0d", st, e.status));
            if (win !== e.winner)
                report($sformatf("winner_id got %h exp %h", win, e.winner));
            if (tot !== e.total)
                report($sformatf("total_tickets got %0d exp %0d", tot, e.total));
        endtask

        task check_drained();
            if (owed.size() != 0)
                report($sformatf("%0d results never arrived", owed.size()));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          kind;
    logic [ID_W-1:0]     client_id;
    logic [TICKET_W-1:0] ticket_amount;
    logic [DRAW_W-1:0]   draw;
    logic                out_valid;
    logic                out_ready;
    logic [2:0]          status;
    logic [ID_W-1:0]     winner_id;
    logic [TOTAL_W-1:0]  total_tickets;

    bit                  steady = 0;
    int                  cycle_count = 0;
    ticket_table_model   model = new();

    lottery_ticket_scheduler #(.MAX_ENTRIES(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .client_id     (client_id),
        .ticket_amount (ticket_amount),
        .draw          (draw),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .winner_id     (winner_id),
        .total_tickets (total_tickets)
    );

    initial clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [TICKET_W-1:0] ticket_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return TICKET_W'($urandom_range(0, 63));
        if (r < 98)
            return TICKET_W'($urandom_range(0, 1023));
        return TICKET_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(logic [1:0] k, logic [ID_W-1:0] id,
                             logic [TICKET_W-1:0] amt, logic [DRAW_W-1:0] d);
        int gap;
        gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        kind          <= k;
        client_id     <= id;
        ticket_amount <= amt;
        draw          <= d;
        do
            @(posedge clk);
        while (!in_ready);
        model.apply_item(k, id, amt, d);
    endtask

    task automatic send_random_item();
        int                  r;
        int                  p;
        int unsigned         tot;
        logic [DRAW_W-1:0]   d;
        r   = $urandom_range(0, 99);
        tot = model.table_total();
        if (r < 8)
        begin
            send_item(lts_pkg::KIND_ADD,
                      ($urandom_range(0, 1) != 0) ? ID_W'($urandom_range(0, 65535))
                                                  : model.pick_id(),
                      ticket_value(), DRAW_W'($urandom_range(0, 1048575)));
        end
        else if (r < 50)
        begin
            send_item(lts_pkg::KIND_ALLOC,
                      ($urandom_range(0, 99) < 85) ? model.pick_id()
                                                   : ID_W'($urandom_range(0, 65535)),
                      ticket_value(), DRAW_W'($urandom_range(0, 1048575)));
        end
        else if (r < 97)
        begin
            p = $urandom_range(0, 99);
            if (p < 80 && tot > 0)
                d = DRAW_W'($urandom_range(1, tot));
            else if (p < 88)
                d = '0;
            else if (p < 95)
                d = DRAW_W'(tot + 1);
            else
                d = DRAW_W'($urandom_range(0, 1048575));
            send_item(lts_pkg::KIND_SELECT, ID_W'($urandom_range(0, 65535)),
                      TICKET_W'($urandom_range(0, 65535)), d);
        end
        else
        begin
            send_item(lts_pkg::KIND_NONE, ID_W'($urandom_range(0, 65535)),
                      TICKET_W'($urandom_range(0, 65535)), DRAW_W'($urandom_range(0, 1048575)));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (idle_len()) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            model.check_result(status, winner_id, total_tickets);
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int n;
        int phase;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        kind          = lts_pkg::KIND_ADD;
        client_id     = '0;
        ticket_amount = '0;
        draw          = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd1);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd0);
        send_item(lts_pkg::KIND_ALLOC,  16'h0000, 16'h0005, 20'd0);
        send_item(lts_pkg::KIND_NONE,   16'h0000, 16'h0000, 20'd0);
        send_item(lts_pkg::KIND_ADD,    16'h0000, 16'h0000, 20'd0);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd1);
        send_item(lts_pkg::KIND_ADD,    16'hFFFF, 16'hFFFF, 20'hFFFFF);
        send_item(lts_pkg::KIND_ADD,    16'h1234, 16'h0001, 20'd0);
        // duplicate id, then credits with saturation
        send_item(lts_pkg::KIND_ADD,    16'hFFFF, 16'h0005, 20'd0);
        send_item(lts_pkg::KIND_ALLOC,  16'hFFFF, 16'h0001, 20'd0);
        send_item(lts_pkg::KIND_ALLOC,  16'hFFFF, 16'hFFFF, 20'd0);
        send_item(lts_pkg::KIND_ALLOC,  16'h0000, 16'h0003, 20'd0);
        send_item(lts_pkg::KIND_ALLOC,  16'hBEEF, 16'h0001, 20'd0);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd0);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd1);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd3);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, 20'd4);
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, DRAW_W'(model.table_total()));
        send_item(lts_pkg::KIND_SELECT, 16'h0000, 16'h0000, DRAW_W'(model.table_total() + 1));
        send_item(lts_pkg::KIND_SELECT, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        send_item(lts_pkg::KIND_NONE,   16'hFFFF, 16'hFFFF, 20'hFFFFF);

        n = 0;
        for (phase = 0; phase * PHASE_ITEMS < RAND_ITEMS; phase++)
        begin
            steady = (phase % 3 == 1);
            if (phase == 2 || phase == 5)
                wait_drained();
            while (n < (phase + 1) * PHASE_ITEMS && n < RAND_ITEMS)
            begin
                send_random_item();
                if (kind != lts_pkg::KIND_NONE)
                    n++;
            end
        end
        steady = 0;

        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);
        model.check_drained();
        if (model.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
hdl/lts_pkg.sv
hdl/lts_ram.sv
hdl/lts_step_unit.sv
hdl/lottery_ticket_scheduler.sv
dv/lottery_ticket_scheduler_test.sv
